// File: design/crsf_pkg.sv
// ---------------------------------------------------------------------------
// CRSF frame receiver package
// Shared types, constants and the CRC-8 byte update used by the receiver.
// ---------------------------------------------------------------------------
package crsf_pkg;

   localparam int MAX_PAYLOAD_BYTES = 60;
   localparam int CHANNEL_COUNT     = 16;
   localparam int CHAN_BYTES        = 22;
   localparam int CHAN_ADDR_W       = $clog2(CHAN_BYTES);
   localparam int CHAN_BITS         = 11;
   localparam int RD_BYTES          = (CHAN_BITS * CHANNEL_COUNT + 7) / 8;
   localparam int ACC_W             = CHAN_BITS + 7;
   localparam int BITS_W            = $clog2(ACC_W + 8 + 1);

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
   localparam logic [1:0] STATUS_CHANNEL = 2'd2;

   localparam logic [1:0] CSR_SYNC_BYTE = 2'd0;
   localparam logic [1:0] CSR_CRC_POLY  = 2'd1;
   localparam logic [1:0] CSR_RC_TYPE   = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_TYPE    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] crc_polynomial;
      logic [7:0] rc_frame_type;
   } cfg_type;

   typedef struct packed {
      logic                   en;
      logic [CHAN_ADDR_W-1:0] addr;
      logic [7:0]             data;
   } wr_type;

   typedef struct packed {
      logic       single_valid;
      logic       unpack_start;
      logic [1:0] status;
      logic [7:0] frame_type;
   } event_type;

   typedef struct packed {
      logic                 valid;
      logic [7:0]           frame_type;
      logic [3:0]           index;
      logic [CHAN_BITS-1:0] value;
      logic                 last;
   } chan_type;

   // One byte of an MSB-first CRC-8, high polynomial bit implicit.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: design/crsf_parser.sv
// ---------------------------------------------------------------------------
// CRSF byte parser
// Tracks the framing, runs the CRC and writes payload bytes to channel RAM.
// ---------------------------------------------------------------------------
module crsf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  logic [7:0]           in_byte,
   input  crsf_pkg::cfg_type    cfg,
   output crsf_pkg::phase_type  phase,
   output crsf_pkg::wr_type     wr,
   output crsf_pkg::event_type  ev
);

   crsf_pkg::phase_type phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] crc_next;
   logic       len_ok;
   logic       payload_done;

   assign crc_next     = crsf_pkg::crc8_byte(
                            (phase_ff == crsf_pkg::PH_TYPE) ? 8'h00 : crc_ff,
                            in_byte, cfg.crc_polynomial);
   assign len_ok       = (in_byte >= 8'd2) &&
                         (in_byte <= 8'(crsf_pkg::MAX_PAYLOAD_BYTES + 2));
   assign payload_done = ({1'b0, pos_ff} + 9'd3) >= {1'b0, len_ff};

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (in_take) begin
         unique case (phase_ff)
            crsf_pkg::PH_LENGTH:  phase_in = len_ok ? crsf_pkg::PH_TYPE : crsf_pkg::PH_HUNT;
            crsf_pkg::PH_TYPE:    phase_in = (len_ff == 8'd2) ? crsf_pkg::PH_CRC
                                                              : crsf_pkg::PH_PAYLOAD;
            crsf_pkg::PH_PAYLOAD: phase_in = payload_done ? crsf_pkg::PH_CRC
                                                          : crsf_pkg::PH_PAYLOAD;
            crsf_pkg::PH_CRC:     phase_in = crsf_pkg::PH_HUNT;
            default:              phase_in = (in_byte == cfg.sync_byte) ? crsf_pkg::PH_LENGTH
                                                                       : crsf_pkg::PH_HUNT;
         endcase
      end
   end

   // Datapath and outputs.
   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      crc_in  = crc_ff;
      type_in = type_ff;
      wr      = '0;
      ev      = '0;
      ev.frame_type = type_ff;
      if (in_take) begin
         unique case (phase_ff)
            crsf_pkg::PH_LENGTH: begin
               if (len_ok) begin
                  len_in = in_byte;
               end
            end
            crsf_pkg::PH_TYPE: begin
               type_in = in_byte;
               crc_in  = crc_next;
               pos_in  = 8'd0;
            end
            crsf_pkg::PH_PAYLOAD: begin
               wr.en   = pos_ff < 8'(crsf_pkg::CHAN_BYTES);
               wr.addr = pos_ff[crsf_pkg::CHAN_ADDR_W-1:0];
               wr.data = in_byte;
               crc_in  = crc_next;
               pos_in  = pos_ff + 8'd1;
            end
            crsf_pkg::PH_CRC: begin
               if (in_byte != crc_ff) begin
                  ev.single_valid = 1'b1;
                  ev.status       = crsf_pkg::STATUS_CRC_BAD;
               end else if ((type_ff == cfg.rc_frame_type) &&
                            (len_ff >= 8'(crsf_pkg::CHAN_BYTES + 2))) begin
                  ev.unpack_start = 1'b1;
                  ev.status       = crsf_pkg::STATUS_CHANNEL;
               end else begin
                  ev.single_valid = 1'b1;
                  ev.status       = crsf_pkg::STATUS_GOOD;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crsf_pkg::PH_HUNT;
         pos_ff   <= 8'd0;
         len_ff   <= 8'd0;
         crc_ff   <= 8'd0;
         type_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         type_ff  <= type_in;
      end
   end

   assign phase = phase_ff;

endmodule

// File: design/crsf_unpack.sv
// ---------------------------------------------------------------------------
// CRSF channel unpacker
// Holds the channel bytes in a RAM and streams them out as 11-bit channels.
// ---------------------------------------------------------------------------
module crsf_unpack (
   input  logic                clock,
   input  logic                reset,
   input  crsf_pkg::wr_type    wr,
   input  crsf_pkg::event_type ev,
   input  logic                out_can_load,
   output logic                busy,
   output crsf_pkg::chan_type  chan
);

   localparam int AW = crsf_pkg::CHAN_ADDR_W;
   localparam int W  = crsf_pkg::ACC_W;
   localparam int BW = crsf_pkg::BITS_W;

   logic [7:0] mem [crsf_pkg::CHAN_BYTES];
   logic [7:0] rd_data_ff;

   logic          busy_ff, busy_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [BW-1:0] bits_ff, bits_in;
   logic [3:0]    chan_ff, chan_in;
   logic [7:0]    type_ff;

   logic [BW-1:0] eff_bits;
   logic [BW-1:0] bits_left;
   logic [W-1:0]  acc_left;
   logic          issue;
   logic          emit;
   logic          last_chan;

   // Bits held plus a byte still coming back from the RAM.
   assign eff_bits  = bits_ff + (pend_ff ? BW'(8) : BW'(0));
   assign issue     = busy_ff && (rd_addr_ff < AW'(crsf_pkg::RD_BYTES)) &&
                      (eff_bits < BW'(crsf_pkg::CHAN_BITS));
   assign emit      = busy_ff && (bits_ff >= BW'(crsf_pkg::CHAN_BITS)) && out_can_load;
   assign last_chan = chan_ff == 4'(crsf_pkg::CHANNEL_COUNT - 1);
   assign bits_left = emit ? bits_ff - BW'(crsf_pkg::CHAN_BITS) : bits_ff;
   assign acc_left  = emit ? (acc_ff >> crsf_pkg::CHAN_BITS) : acc_ff;

   always_comb begin
      busy_in    = busy_ff;
      pend_in    = issue;
      rd_addr_in = issue ? rd_addr_ff + AW'(1) : rd_addr_ff;
      acc_in     = acc_left;
      bits_in    = bits_left;
      chan_in    = emit ? chan_ff + 4'd1 : chan_ff;
      if (pend_ff) begin
         acc_in  = acc_left | (W'(rd_data_ff) << bits_left);
         bits_in = bits_left + BW'(8);
      end
      if (emit && last_chan) begin
         busy_in = 1'b0;
      end
      if (ev.unpack_start) begin
         busy_in    = 1'b1;
         pend_in    = 1'b0;
         rd_addr_in = '0;
         acc_in     = '0;
         bits_in    = '0;
         chan_in    = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         rd_addr_ff <= '0;
         bits_ff    <= '0;
         chan_ff    <= 4'd0;
      end else begin
         busy_ff    <= busy_in;
         pend_ff    <= pend_in;
         rd_addr_ff <= rd_addr_in;
         bits_ff    <= bits_in;
         chan_ff    <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ev.unpack_start) begin
         type_ff <= ev.frame_type;
      end
   end

   // Channel byte RAM: one write port from the parser, one registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   assign busy = busy_ff;

   always_comb begin
      chan.valid      = emit;
      chan.frame_type = type_ff;
      chan.index      = chan_ff;
      chan.value      = acc_ff[crsf_pkg::CHAN_BITS-1:0];
      chan.last       = last_chan;
   end

endmodule

// File: design/crsf_out_stage.sv
// ---------------------------------------------------------------------------
// CRSF result register
// Holds one result word for the output stream and merges the two sources.
// ---------------------------------------------------------------------------
module crsf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  crsf_pkg::event_type ev,
   input  crsf_pkg::chan_type  chan,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [1:0]  status_ff;
   logic [7:0]  type_ff;
   logic [3:0]  index_ff;
   logic [10:0] value_ff;
   logic        last_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (ev.single_valid || chan.valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chan.valid) begin
         status_ff <= crsf_pkg::STATUS_CHANNEL;
         type_ff   <= chan.frame_type;
         index_ff  <= chan.index;
         value_ff  <= chan.value;
         last_ff   <= chan.last;
      end else if (ev.single_valid) begin
         status_ff <= ev.status;
         type_ff   <= ev.frame_type;
         index_ff  <= 4'd0;
         value_ff  <= 11'd0;
         last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, value_ff, index_ff, type_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: design/crsf_frame_receiver_top.sv
// ---------------------------------------------------------------------------
// CRSF frame receiver
// Parses CRSF frames from a byte stream, checks the CRC and unpacks channels.
// ---------------------------------------------------------------------------
// Usage:
// Bytes from the serial link enter on the req_ stream, one byte per word.
// Results leave on the rsp_ stream. Each completed frame yields one word with
// its type and a status of good or CRC mismatch, or, for a good RC-channels
// frame with at least 22 payload bytes, sixteen channel words in order.
// tlast marks the final word caused by one input byte.
// A single-word result is valid from the clock edge that accepts its CRC byte.
// Channel words come from a 22-byte channel RAM with one registered read
// port. A byte is fetched only while fewer than 11 bits are held or on the
// way, and passes through the RAM read register into the bit accumulator,
// from which each channel is loaded into the result register.
// Sync, length and type bytes are taken every cycle. While channels are
// still being unpacked, payload and CRC bytes of the next frame are held off.
// A stalled receiver holds the result word and stalls the unpacker; this
// backs up into the parser at the next frame's payload or CRC byte.
// Reset restores the default sync byte, polynomial and RC frame type and
// returns the parser to hunting; the channel RAM is not cleared.
// The csr_ port is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module crsf_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] frame_type, [11:8] channel_index,
                                    // [22:12] channel_value, [23] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,   // last
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   crsf_pkg::cfg_type   cfg_ff;
   crsf_pkg::phase_type phase;
   crsf_pkg::wr_type    wr;
   crsf_pkg::event_type ev;
   crsf_pkg::chan_type  chan;
   logic                in_take;
   logic                unpack_busy;
   logic                out_can_load;

   assign csr_ready = 1'b1;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte      <= 8'd200;
         cfg_ff.crc_polynomial <= 8'd213;
         cfg_ff.rc_frame_type  <= 8'd22;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crsf_pkg::CSR_SYNC_BYTE: cfg_ff.sync_byte      <= csr_data;
            crsf_pkg::CSR_CRC_POLY:  cfg_ff.crc_polynomial <= csr_data;
            crsf_pkg::CSR_RC_TYPE:   cfg_ff.rc_frame_type  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Payload bytes would overwrite the RAM the unpacker is reading, and a
   // CRC byte may need the output register, so those wait.
   always_comb begin
      unique case (phase)
         crsf_pkg::PH_PAYLOAD: req_tready = !unpack_busy;
         crsf_pkg::PH_CRC:     req_tready = !unpack_busy && out_can_load;
         default:              req_tready = 1'b1;
      endcase
   end

   assign in_take = req_tvalid && req_tready;

   crsf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_take (in_take),
      .in_byte (req_tdata),
      .cfg     (cfg_ff),
      .phase   (phase),
      .wr      (wr),
      .ev      (ev)
   );

   crsf_unpack u_unpack (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .ev           (ev),
      .out_can_load (out_can_load),
      .busy         (unpack_busy),
      .chan         (chan)
   );

   crsf_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ev         (ev),
      .chan       (chan),
      .can_load   (out_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/crsf_frame_receiver_checker.sv
// ---------------------------------------------------------------------------
// CRSF frame receiver checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
module crsf_frame_receiver_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // The status code is never the unused value.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == crsf_pkg::STATUS_GOOD ||
                     rsp_tuser == crsf_pkg::STATUS_CRC_BAD ||
                     rsp_tuser == crsf_pkg::STATUS_CHANNEL)
      else $error("unused status code");

   // Frame results are single words with no channel fields.
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != crsf_pkg::STATUS_CHANNEL |->
      rsp_tlast && rsp_tdata[23:8] == 16'd0)
      else $error("frame result carries channel fields");

   // No result word survives a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind crsf_frame_receiver_top crsf_frame_receiver_checker u_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// CRSF frame receiver testbench
// Feeds byte streams of framed, broken and noisy CRSF traffic into the
// receiver under several register settings. A scoreboard predicts every
// result word from its own parser and checks the result stream field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // A long receiver hold-off lets the parser back up and stall its input.
   localparam int HOLD_CYCLES   = 400;
   // After the last expected word, leave the channel unpacker time to settle.
   localparam int SETTLE_CYCLES = 40;
   // Generous bound on the whole run; the slowest correct run is far below it.
   localparam int CYCLE_LIMIT   = 50000;

   // One predicted result word, with the fields in the order the block reports.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  frame_type;
      logic [3:0]  index;
      logic [10:0] value;
      logic        is_last;
   } frame_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a byte-level CRSF parser that predicts result words, and the
   // queue of words still owed by the block.
   // -------------------------------------------------------------------------
   class crsf_scoreboard;
      logic [7:0]          sync_val;
      logic [7:0]          poly_val;
      logic [7:0]          rc_type_val;
      crsf_pkg::phase_type parse_phase;
      int                  payload_pos;
      logic [7:0]          frame_len;
      logic [7:0]          crc_acc;
      logic [7:0]          frame_type;
      logic [7:0]          chan_mem [crsf_pkg::CHAN_BYTES];
      frame_result_type    pending [$];
      int                  errors;
      int                  predicted;

      function new();
         sync_val    = 8'd200;
         poly_val    = 8'd213;
         rc_type_val = 8'd22;
         parse_phase = crsf_pkg::PH_HUNT;
         payload_pos = 0;
         frame_len   = 8'h00;
         crc_acc     = 8'h00;
         frame_type  = 8'h00;
         foreach (chan_mem[i]) chan_mem[i] = 8'h00;
         errors      = 0;
         predicted   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] v);
         case (idx)
            crsf_pkg::CSR_SYNC_BYTE: sync_val    = v;
            crsf_pkg::CSR_CRC_POLY:  poly_val    = v;
            crsf_pkg::CSR_RC_TYPE:   rc_type_val = v;
            default: ;
         endcase
      endfunction

      // MSB-first CRC-8 over one byte with the current polynomial.
      function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
         logic [7:0] c;
         c = crc ^ b;
         repeat (8) begin
            if (c[7]) c = {c[6:0], 1'b0} ^ poly_val;
            else      c = {c[6:0], 1'b0};
         end
         return c;
      endfunction

      function logic [7:0] chan_byte(int i);
         return (i < crsf_pkg::CHAN_BYTES) ? chan_mem[i] : 8'h00;
      endfunction

      // Channel k sits at bit 11*k of the little-endian payload bit stream.
      function logic [10:0] channel_at(int k);
         int         bitpos;
         logic [23:0] w;
         bitpos = 11 * k;
         w = {chan_byte(bitpos / 8 + 2), chan_byte(bitpos / 8 + 1), chan_byte(bitpos / 8)};
         w = w >> (bitpos % 8);
         return w[10:0];
      endfunction

      function void push_word(logic [1:0] st, logic [3:0] ix, logic [10:0] val, logic lst);
         frame_result_type r;
         r.status     = st;
         r.frame_type = frame_type;
         r.index      = ix;
         r.value      = val;
         r.is_last    = lst;
         pending.push_back(r);
         predicted++;
      endfunction

      function void note_byte(logic [7:0] b);
         case (parse_phase)
            crsf_pkg::PH_LENGTH: begin
               if (b >= 8'd2 && int'(b) <= crsf_pkg::MAX_PAYLOAD_BYTES + 2) begin
                  frame_len   = b;
                  parse_phase = crsf_pkg::PH_TYPE;
               end else begin
                  parse_phase = crsf_pkg::PH_HUNT;
               end
            end
            crsf_pkg::PH_TYPE: begin
               frame_type  = b;
               crc_acc     = crc_step(8'h00, b);
               payload_pos = 0;
               parse_phase = (frame_len == 8'd2) ? crsf_pkg::PH_CRC : crsf_pkg::PH_PAYLOAD;
            end
            crsf_pkg::PH_PAYLOAD: begin
               if (payload_pos < crsf_pkg::CHAN_BYTES) chan_mem[payload_pos] = b;
               crc_acc     = crc_step(crc_acc, b);
               payload_pos = payload_pos + 1;
               if (payload_pos + 2 >= int'(frame_len)) parse_phase = crsf_pkg::PH_CRC;
            end
            crsf_pkg::PH_CRC: begin
               parse_phase = crsf_pkg::PH_HUNT;
               if (b != crc_acc) begin
                  push_word(crsf_pkg::STATUS_CRC_BAD, 4'd0, 11'd0, 1'b1);
               end else if (frame_type == rc_type_val &&
                            int'(frame_len) - 2 >= crsf_pkg::CHAN_BYTES) begin
                  for (int k = 0; k < crsf_pkg::CHANNEL_COUNT; k++)
                     push_word(crsf_pkg::STATUS_CHANNEL, 4'(k), channel_at(k),
                               k == crsf_pkg::CHANNEL_COUNT - 1);
               end else begin
                  push_word(crsf_pkg::STATUS_GOOD, 4'd0, 11'd0, 1'b1);
               end
            end
            default: begin
               parse_phase = (b == sync_val) ? crsf_pkg::PH_LENGTH : crsf_pkg::PH_HUNT;
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_word(logic [1:0] st, logic [7:0] ft, logic [3:0] ix, logic [10:0] val,
                      logic lst, logic pad);
         frame_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word status %0d type %02h ch %0d value %0d",
                             st, ft, ix, val));
            return;
         end
         e = pending.pop_front();
         if (st !== e.status)
            report($sformatf("status %0d, expected %0d", st, e.status));
         if (ft !== e.frame_type)
            report($sformatf("frame type %02h, expected %02h", ft, e.frame_type));
         if (ix !== e.index)
            report($sformatf("channel index %0d, expected %0d", ix, e.index));
         if (val !== e.value)
            report($sformatf("channel %0d value %0d, expected %0d", e.index, val, e.value));
         if (lst !== e.is_last)
            report($sformatf("tlast %b, expected %b", lst, e.is_last));
         if (pad !== 1'b0)
            report("tdata padding bit is not zero");
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test.
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = crsf_pkg::CSR_SYNC_BYTE;
   logic [7:0]  csr_data   = 8'h00;

   // Idle rates in percent for the sender and the receiver; the directed
   // part runs with no idling at all.
   int idle_pct  = 0;
   int stall_pct = 0;

   // The stimulus asks for a receiver hold-off by bumping this count.
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   int cycles     = 0;
   int bytes_sent = 0;

   crsf_scoreboard sb;

   always #2 clock = ~clock;

   crsf_frame_receiver_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // The run ends here if the block stops making progress.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver side. Ready changes at the falling edge. A requested hold-off
   // keeps it low for a long stretch, counted here cycle by cycle; otherwise
   // it drops at random at the current stall rate.
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result monitor. Values read just after the rising edge are the ones
   // that were present at the edge, so every accepted word is seen once.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tuser, rsp_tdata[7:0], rsp_tdata[11:8], rsp_tdata[22:12],
                       rsp_tlast, rsp_tdata[23]);
   end

   // -------------------------------------------------------------------------
   // Driving tasks.
   // -------------------------------------------------------------------------

   // Offer one byte word, with random idle cycles ahead of it. Valid stays
   // high after acceptance; the next call or end_burst decides what follows,
   // so valid is never dropped and raised again at the same edge.
   task send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Wait until every predicted word has come back, then let the block settle.
   task drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only issued while the block is idle.
   task csr_write(input logic [1:0] idx, input logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task set_config(input logic [7:0] sync_v, input logic [7:0] poly_v,
                   input logic [7:0] rc_v);
      csr_write(crsf_pkg::CSR_SYNC_BYTE, sync_v);
      csr_write(crsf_pkg::CSR_CRC_POLY, poly_v);
      csr_write(crsf_pkg::CSR_RC_TYPE, rc_v);
   endtask

   // A complete frame with the current sync byte and polynomial. A negative
   // fill gives random payload bytes; a set bad_crc corrupts the check byte.
   task send_frame(input logic [7:0] ftype, input int plen, input int fill,
                   input bit bad_crc);
      logic [7:0] crc;
      logic [7:0] pb;
      send_byte(sb.sync_val);
      send_byte(8'(plen + 2));
      send_byte(ftype);
      crc = sb.crc_step(8'h00, ftype);
      for (int i = 0; i < plen; i++) begin
         pb  = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
         crc = sb.crc_step(crc, pb);
         send_byte(pb);
      end
      if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
      send_byte(crc);
   endtask

   // Mostly well-formed frames with random content, plus noise, bad lengths
   // and cut-off frames. Runs until both the byte and the result counts for
   // this stretch are met.
   task random_traffic(input int min_bytes, input int min_results);
      int         start_bytes;
      int         start_results;
      int         pick;
      int         plen;
      logic [7:0] ftype;
      start_bytes   = bytes_sent;
      start_results = sb.predicted;
      while (bytes_sent - start_bytes < min_bytes ||
             sb.predicted - start_results < min_results) begin
         pick  = $urandom_range(99);
         ftype = ($urandom_range(3) == 0) ? sb.rc_type_val : 8'($urandom_range(255));
         if (pick < 50) begin
            // Short frame; an RC type here exercises the short RC case.
            send_frame(ftype, $urandom_range(0, 8), -1, $urandom_range(9) == 0);
         end else if (pick < 68) begin
            // Channel frame, now and then with the longest payload.
            plen = ($urandom_range(7) == 0) ? crsf_pkg::MAX_PAYLOAD_BYTES
                                            : $urandom_range(22, 28);
            send_frame(sb.rc_type_val, plen, -1, $urandom_range(7) == 0);
         end else if (pick < 76) begin
            send_frame(ftype, $urandom_range(9, crsf_pkg::MAX_PAYLOAD_BYTES), -1,
                       $urandom_range(5) == 0);
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end else if (pick < 93) begin
            // Sync followed by a length outside the legal range.
            send_byte(sb.sync_val);
            send_byte(($urandom_range(1) == 0) ? 8'($urandom_range(1))
                      : 8'($urandom_range(crsf_pkg::MAX_PAYLOAD_BYTES + 3, 255)));
         end else begin
            // Frame cut off early; following bytes complete it.
            plen = $urandom_range(0, 30);
            send_byte(sb.sync_val);
            send_byte(8'(plen + 2));
            send_byte(ftype);
            repeat ($urandom_range(0, plen)) send_byte(8'($urandom_range(255)));
         end
      end
      end_burst();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings. Noise bytes that are not sync.
      send_byte(8'h00);
      send_byte(8'hFF);
      // Lengths just below, just above and far outside the legal range.
      send_byte(sb.sync_val);
      send_byte(8'd0);
      send_byte(sb.sync_val);
      send_byte(8'd1);
      send_byte(sb.sync_val);
      send_byte(8'(crsf_pkg::MAX_PAYLOAD_BYTES + 3));
      send_byte(sb.sync_val);
      send_byte(8'hFF);
      // A rejected length byte equal to sync must not start a new frame, so
      // the byte after it is ignored.
      send_byte(sb.sync_val);
      send_byte(sb.sync_val);
      send_byte(8'd5);
      // Empty payloads, good and bad.
      send_frame(8'h00, 0, -1, 1'b0);
      send_frame(8'h80, 0, -1, 1'b1);
      // Longest payload: only the first bytes feed the channels.
      send_frame(sb.rc_type_val, crsf_pkg::MAX_PAYLOAD_BYTES, -1, 1'b0);
      end_burst();
      drain();

      // Back-pressure: the receiver holds off while channel frames keep
      // coming, so the result path fills and the parser stalls its input.
      // All ones, all zeros and a broken check byte.
      idle_pct  = 8;
      stall_pct = 8;
      hold_requests++;
      send_frame(sb.rc_type_val, 22, 8'hFF, 1'b0);
      send_frame(sb.rc_type_val, 22, 8'h00, 1'b0);
      send_frame(sb.rc_type_val, 22, -1, 1'b1);
      end_burst();
      drain();

      // Lowest sync byte and highest RC type with a common polynomial.
      set_config(8'h00, 8'h07, 8'hFF);
      random_traffic(10, 1);
      drain();

      // A zero polynomial and the top sync byte.
      set_config(8'hFF, 8'h00, 8'h00);
      random_traffic(10, 1);
      drain();

      // Random sync and RC type with the full polynomial.
      set_config(8'($urandom_range(255)), 8'hFF, 8'($urandom_range(255)));
      random_traffic(10, 1);
      drain();

      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
